@@ rtl/pol_pkg.sv @@
// ----------------------------------------------------------------------------
// pol_pkg
// shared opcodes, status codes, field widths and cell control type for the
// positional ordered list
// ----------------------------------------------------------------------------
package pol_pkg;

    // payload field widths
    localparam int OP_W     = 2;
    localparam int POS_W    = 6;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOCATE = 2'd2;
    localparam logic [OP_W-1:0] OP_GET    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // shift command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

@@ rtl/pol_if.sv @@
// ----------------------------------------------------------------------------
// pol_if
// request and response channels of the positional ordered list
// ----------------------------------------------------------------------------
interface pol_in_if;
    logic                                valid;
    logic                                ready;
    logic [pol_pkg::OP_W-1:0]            opcode;
    logic [pol_pkg::POS_W-1:0]           position;
    logic signed [pol_pkg::DATA_W-1:0]   item_value;

    modport source (output valid, output opcode, output position, output item_value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input item_value,
                    output ready);
endinterface

interface pol_out_if;
    logic                                valid;
    logic                                ready;
    logic [pol_pkg::STATUS_W-1:0]        status;
    logic signed [pol_pkg::DATA_W-1:0]   result_value;
    logic [pol_pkg::POS_W-1:0]           found_position;
    logic [pol_pkg::POS_W-1:0]           list_length;
    logic                                is_empty;

    modport source (output valid, output status, output result_value,
                    output found_position, output list_length, output is_empty,
                    input ready);
    modport sink   (input valid, input status, input result_value,
                    input found_position, input list_length, input is_empty,
                    output ready);
endinterface

@@ rtl/pol_cell.sv @@
// ----------------------------------------------------------------------------
// pol_cell
// one list slot: holds a value, shifts from its neighbors on insert and
// delete, and flags a key match and a position select
// ----------------------------------------------------------------------------
module pol_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int IDX_WIDTH   = 5,
    parameter int CNT_WIDTH   = 6,
    parameter int CELL_INDEX  = 0
) (
    input  logic                   i_clk,
    input  pol_pkg::t_cell_ctl     i_ctl,
    input  logic [IDX_WIDTH-1:0]   i_tgt,
    input  logic [CNT_WIDTH-1:0]   i_count,
    input  logic [VALUE_WIDTH-1:0] i_key,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_hit,
    output logic                   o_sel
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    logic                   w_eq;
    logic                   w_gt;

    assign w_eq = (i_tgt == IDX_WIDTH'(CELL_INDEX));
    assign w_gt = (IDX_WIDTH'(CELL_INDEX) > i_tgt);

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (w_eq) begin
                n_value = i_key;
            end else if (w_gt) begin
                n_value = i_left;
            end
        end else if (i_ctl.del) begin
            if (w_eq || w_gt) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // only slots below the fill count take part in a search
    assign o_hit   = (CNT_WIDTH'(CELL_INDEX) < i_count) && (r_value == i_key);
    assign o_sel   = w_eq;
    assign o_value = r_value;

endmodule

@@ rtl/positional_ordered_list_core.sv @@
// ----------------------------------------------------------------------------
// positional_ordered_list_core
// bounded ordered list of signed values kept in a shifting chain of cells
// ----------------------------------------------------------------------------
// usage
//   i_in  (sink)   : one request per transaction: opcode, 1-based position
//                    and item_value (insert, delete, locate, get)
//   o_out (source) : exactly one response per request, in request order:
//                    status, result_value, found_position, list_length,
//                    is_empty
// timing
//   three-stage pipeline: request register, cell update, response register
//   throughput is one transaction per cycle unless o_out stalls; the cell
//   chain updates all slots at once and the search result is encoded one
//   stage later
// reset
//   i_rst_n low empties the list and drops all transactions in flight;
//   cell contents are not cleared, slots past the fill count are never read
// back-pressure
//   while o_out holds a response that is not taken the whole pipeline
//   freezes and i_in.ready drops; a new request can still sit in the first
//   stage behind a waiting response
// ----------------------------------------------------------------------------
module positional_ordered_list_core #(
    parameter int CAPACITY    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pol_in_if.sink      i_in,
    pol_out_if.source   o_out
);

    // widths derived from the capacity and the field widths
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IW  = $clog2(CAPACITY);
    localparam int PW  = ((CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W) + 1;
    localparam int MW  = (VALUE_WIDTH < pol_pkg::DATA_W) ? VALUE_WIDTH : pol_pkg::DATA_W;

    // pipeline enable: everything moves unless a response is stuck
    logic w_en;

    // stage 1: request register
    logic                           r_v1;
    logic [pol_pkg::OP_W-1:0]       r_op;
    logic [pol_pkg::POS_W-1:0]      r_pos;
    logic [VALUE_WIDTH-1:0]         r_key;

    // fill count
    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  n_count;

    // stage 2: cell results
    logic                           r_v2;
    logic [pol_pkg::STATUS_W-1:0]   r_status;
    logic [VALUE_WIDTH-1:0]         r_rdata;
    logic [CW-1:0]                  r_len;
    logic                           r_is_loc;
    logic [CAPACITY-1:0]            r_hit;

    // response register
    logic                           r_out_valid;
    logic [pol_pkg::STATUS_W-1:0]   r_out_status;
    logic [pol_pkg::DATA_W-1:0]     r_out_value;
    logic [pol_pkg::POS_W-1:0]      r_out_found;
    logic [pol_pkg::POS_W-1:0]      r_out_len;
    logic                           r_out_empty;

    // stage 1 decode
    logic [PW-1:0]                  w_pos;
    logic [PW-1:0]                  w_n;
    logic                           w_ins_bad;
    logic                           w_rd_bad;
    logic                           w_full;
    logic [IW-1:0]                  w_tgt;
    logic [pol_pkg::STATUS_W-1:0]   w_status;
    logic                           w_rd_ok;
    pol_pkg::t_cell_ctl             w_ctl;

    // cell chain
    logic [VALUE_WIDTH-1:0]         w_cell_value [CAPACITY];
    logic [CAPACITY-1:0]            w_hit;
    logic [CAPACITY-1:0]            w_sel;
    logic [VALUE_WIDTH-1:0]         w_rdata;

    // stage 2 encode
    logic [CW-1:0]                  w_found;

    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in.valid;
        end
    end

    // values keep their low MW bits, zero above
    always_ff @(posedge i_clk) begin
        if (w_en && i_in.valid) begin
            r_op  <= i_in.opcode;
            r_pos <= i_in.position;
            r_key <= VALUE_WIDTH'(i_in.item_value[MW-1:0]);
        end
    end

    // range checks against the fill count
    assign w_pos     = PW'(r_pos);
    assign w_n       = PW'(r_count);
    assign w_ins_bad = (r_pos == '0) || (w_pos > (w_n + PW'(1)));
    assign w_rd_bad  = (r_pos == '0) || (w_pos > w_n);
    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_tgt     = IW'(w_pos - PW'(1));

    always_comb begin
        w_status = pol_pkg::ST_OK;
        w_rd_ok  = 1'b0;
        w_ctl    = '0;
        n_count  = r_count;
        case (r_op)
            pol_pkg::OP_INSERT: begin
                if (w_ins_bad) begin
                    w_status = pol_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = pol_pkg::ST_FULL;
                end else begin
                    w_ctl.ins = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            pol_pkg::OP_DELETE: begin
                if (w_rd_bad) begin
                    w_status = pol_pkg::ST_RANGE;
                end else begin
                    w_ctl.del = 1'b1;
                    w_rd_ok   = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            pol_pkg::OP_GET: begin
                if (w_rd_bad) begin
                    w_status = pol_pkg::ST_RANGE;
                end else begin
                    w_rd_ok = 1'b1;
                end
            end
            default: begin
                // locate: no change to the list
            end
        endcase
        // the chain only shifts on a live, moving transaction
        if (!(r_v1 && w_en)) begin
            w_ctl   = '0;
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // row of neighbor-fed cells; the first takes r_key, the last itself
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [VALUE_WIDTH-1:0] w_left;
            logic [VALUE_WIDTH-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = r_key;
            end else begin : g_mid_l
                assign w_left = w_cell_value[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_cell_value[g];
            end else begin : g_mid_r
                assign w_right = w_cell_value[g+1];
            end
            pol_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .IDX_WIDTH   (IW),
                .CNT_WIDTH   (CW),
                .CELL_INDEX  (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_tgt       (w_tgt),
                .i_count     (r_count),
                .i_key       (r_key),
                .i_left      (w_left),
                .i_right     (w_right),
                .o_value     (w_cell_value[g]),
                .o_hit       (w_hit[g]),
                .o_sel       (w_sel[g])
            );
        end
    endgenerate

    // and-or read of the selected slot
    always_comb begin
        w_rdata = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rdata = w_rdata | (w_cell_value[k] & {VALUE_WIDTH{w_sel[k]}});
        end
    end

    // stage 2 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_v1) begin
            r_status <= w_status;
            r_rdata  <= w_rd_ok ? w_rdata : '0;
            r_len    <= n_count;
            r_is_loc <= (r_op == pol_pkg::OP_LOCATE);
            r_hit    <= w_hit;
        end
    end

    // first matching slot wins
    always_comb begin
        w_found = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (r_hit[k]) begin
                w_found = CW'(k + 1);
            end
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_v2) begin
            r_out_status <= r_status;
            r_out_value  <= pol_pkg::DATA_W'(r_rdata[MW-1:0]);
            r_out_found  <= r_is_loc ? pol_pkg::POS_W'(w_found) : '0;
            r_out_len    <= pol_pkg::POS_W'(r_len);
            r_out_empty  <= (r_len == '0);
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.result_value   = r_out_value;
    assign o_out.found_position = r_out_found;
    assign o_out.list_length    = r_out_len;
    assign o_out.is_empty       = r_out_empty;

    // fill count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // an accepted insert grows the list by one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.ins) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    // an accepted delete shrinks the list by one
    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.del) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not shrink the list");

    // full status only comes from a list that is full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && (r_status == pol_pkg::ST_FULL)) |-> (r_count == CW'(CAPACITY)))
        else $error("full status on a list with room");

    // a rejected request returns no value
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != pol_pkg::ST_OK)) |-> (r_out_value == '0))
        else $error("rejected request returned a value");

endmodule
